// ----- hdl/tjs_pkg.sv -----
// Shared types and constants for the two-joint PD servo step block.
`default_nettype none

package tjs_pkg;

	localparam int DATA_W     = 32;
	localparam int LIM_W      = 31;
	localparam int STEP_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int NUM_STAGES = 9;

	// Register map of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP0   = 3'd0,
		REG_KP1   = 3'd1,
		REG_KD0   = 3'd2,
		REG_KD1   = 3'd3,
		REG_VLIM  = 3'd4,
		REG_STEP  = 3'd5
	} cfg_reg_t;

	// Per-stage load strobes from the pipeline control
	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} pipe_ctl_t;

	// Settings seen by one joint datapath
	typedef struct packed {
		logic [DATA_W-1:0] kp;
		logic [DATA_W-1:0] kd;
		logic [LIM_W-1:0]  lim;
		logic [STEP_W-1:0] h;
	} joint_cfg_t;

endpackage

`default_nettype wire

// ----- hdl/tjs_item_if.sv -----
// Valid/ready channel carrying one two-joint state request.
`default_nettype none

interface tjs_item_if
	import tjs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] angle_0;
	logic [DATA_W-1:0] angle_1;
	logic [DATA_W-1:0] rate_0;
	logic [DATA_W-1:0] rate_1;
	logic [DATA_W-1:0] target_angle_0;
	logic [DATA_W-1:0] target_angle_1;
	logic [DATA_W-1:0] target_rate_0;
	logic [DATA_W-1:0] target_rate_1;

	modport source (
		output valid, angle_0, angle_1, rate_0, rate_1,
		       target_angle_0, target_angle_1, target_rate_0, target_rate_1,
		input  ready
	);

	modport sink (
		input  valid, angle_0, angle_1, rate_0, rate_1,
		       target_angle_0, target_angle_1, target_rate_0, target_rate_1,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/tjs_result_if.sv -----
// Valid/ready channel carrying one stepped two-joint result.
`default_nettype none

interface tjs_result_if
	import tjs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] next_angle_0;
	logic [DATA_W-1:0] next_angle_1;
	logic [DATA_W-1:0] next_rate_0;
	logic [DATA_W-1:0] next_rate_1;
	logic [DATA_W-1:0] next_target_0;
	logic [DATA_W-1:0] next_target_1;

	modport source (
		output valid, next_angle_0, next_angle_1, next_rate_0, next_rate_1,
		       next_target_0, next_target_1,
		input  ready
	);

	modport sink (
		input  valid, next_angle_0, next_angle_1, next_rate_0, next_rate_1,
		       next_target_0, next_target_1,
		output ready
	);
endinterface

`default_nettype wire

// ----- hdl/tjs_joint.sv -----
// Nine-stage datapath for one joint: PD law, velocity and angle integration.
`default_nettype none

module tjs_joint
	import tjs_pkg::*;
(
	input  wire logic                     clk,
	input  wire pipe_ctl_t                ctl,
	input  wire joint_cfg_t               cfg,
	input  wire logic signed [DATA_W-1:0] ang,
	input  wire logic signed [DATA_W-1:0] rate,
	input  wire logic signed [DATA_W-1:0] tgt,
	input  wire logic signed [DATA_W-1:0] trate,
	output logic signed [DATA_W-1:0]      next_ang,
	output logic signed [DATA_W-1:0]      next_rate,
	output logic signed [DATA_W-1:0]      next_tgt
);

	localparam logic signed [64:0] S32_MAX = 65'sd2147483647;
	localparam logic signed [64:0] S32_MIN = -65'sd2147483648;

	// round(p / 2^sh), half away from zero
	function automatic logic signed [64:0] rnd(input logic signed [64:0] p,
	                                           input int unsigned sh);
		logic signed [64:0] t;
		t = p + (65'sd1 <<< (sh - 1)) - $signed({64'd0, p[64]});
		return t >>> sh;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [64:0] x);
		logic signed [64:0] y;
		y = x;
		if (x > S32_MAX)
			y = S32_MAX;
		else if (x < S32_MIN)
			y = S32_MIN;
		return DATA_W'(y);
	endfunction

	logic signed [STEP_W:0] h_s;
	assign h_s = $signed({1'b0, cfg.h});

	// Stage 1: position and velocity errors
	logic signed [32:0]       ep_s1, ed_s1;
	logic signed [DATA_W-1:0] ang_s1, rate_s1, tgt_s1, trate_s1;

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			ep_s1    <= 33'(tgt) - 33'(ang);
			ed_s1    <= 33'(trate) - 33'(rate);
			ang_s1   <= ang;
			rate_s1  <= rate;
			tgt_s1   <= tgt;
			trate_s1 <= trate;
		end
	end

	// Stage 2: gain products and h*target_rate
	logic signed [65:0]       pp_full, pd_full;
	logic signed [48:0]       pt_full;
	logic signed [64:0]       pp_s2, pd_s2;
	logic signed [48:0]       pt_s2;
	logic signed [DATA_W-1:0] ang_s2, rate_s2, tgt_s2;

	assign pp_full = ep_s1 * $signed({1'b0, cfg.kp});
	assign pd_full = ed_s1 * $signed({1'b0, cfg.kd});
	assign pt_full = trate_s1 * h_s;

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			pp_s2   <= pp_full[64:0];
			pd_s2   <= pd_full[64:0];
			pt_s2   <= pt_full;
			ang_s2  <= ang_s1;
			rate_s2 <= rate_s1;
			tgt_s2  <= tgt_s1;
		end
	end

	// Stage 3: round gain terms, finish target update
	logic signed [48:0]       rp_s3, rd_s3;
	logic signed [DATA_W-1:0] ang_s3, rate_s3, ntgt_s3;

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			rp_s3   <= 49'(rnd(pp_s2, 16));
			rd_s3   <= 49'(rnd(pd_s2, 16));
			ntgt_s3 <= sat32(65'(tgt_s2) + rnd(65'(pt_s2), 16));
			ang_s3  <= ang_s2;
			rate_s3 <= rate_s2;
		end
	end

	// Stage 4: acceleration, saturated
	logic signed [DATA_W-1:0] acc_s4, ang_s4, rate_s4, ntgt_s4;

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			acc_s4  <= sat32(65'(rp_s3) + 65'(rd_s3));
			ang_s4  <= ang_s3;
			rate_s4 <= rate_s3;
			ntgt_s4 <= ntgt_s3;
		end
	end

	// Stage 5: h*acc
	logic signed [48:0]       ha_full, ha_s5;
	logic signed [DATA_W-1:0] ang_s5, rate_s5, ntgt_s5;

	assign ha_full = acc_s4 * h_s;

	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			ha_s5   <= ha_full;
			ang_s5  <= ang_s4;
			rate_s5 <= rate_s4;
			ntgt_s5 <= ntgt_s4;
		end
	end

	// Stage 6: new velocity, clamped to +/- limit
	logic signed [64:0]       v_raw, v_clamp, lim_s;
	logic signed [DATA_W-1:0] v_s6, ang_s6, rate_s6, ntgt_s6;

	always_comb begin
		lim_s = $signed({34'd0, cfg.lim});
		v_raw = 65'(rate_s5) + rnd(65'(ha_s5), 16);
		if (v_raw > lim_s)
			v_clamp = lim_s;
		else if (v_raw < -lim_s)
			v_clamp = -lim_s;
		else
			v_clamp = v_raw;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			v_s6    <= DATA_W'(v_clamp);
			ang_s6  <= ang_s5;
			rate_s6 <= rate_s5;
			ntgt_s6 <= ntgt_s5;
		end
	end

	// Stage 7: old plus new velocity
	logic signed [32:0]       vsum_s7;
	logic signed [DATA_W-1:0] v_s7, ang_s7, ntgt_s7;

	always_ff @(posedge clk) begin
		if (ctl.load[6]) begin
			vsum_s7 <= 33'(v_s6) + 33'(rate_s6);
			v_s7    <= v_s6;
			ang_s7  <= ang_s6;
			ntgt_s7 <= ntgt_s6;
		end
	end

	// Stage 8: h*(v_new + v_old)
	logic signed [49:0]       pa_full, pa_s8;
	logic signed [DATA_W-1:0] v_s8, ang_s8, ntgt_s8;

	assign pa_full = vsum_s7 * h_s;

	always_ff @(posedge clk) begin
		if (ctl.load[7]) begin
			pa_s8   <= pa_full;
			v_s8    <= v_s7;
			ang_s8  <= ang_s7;
			ntgt_s8 <= ntgt_s7;
		end
	end

	// Stage 9: trapezoid angle update (half step folded into the shift)
	logic signed [DATA_W-1:0] nang_s9, v_s9, ntgt_s9;

	always_ff @(posedge clk) begin
		if (ctl.load[8]) begin
			nang_s9 <= sat32(65'(ang_s8) + rnd(65'(pa_s8), 17));
			v_s9    <= v_s8;
			ntgt_s9 <= ntgt_s8;
		end
	end

	assign next_ang  = nang_s9;
	assign next_rate = v_s9;
	assign next_tgt  = ntgt_s9;

endmodule

`default_nettype wire

// ----- hdl/two_joint_pd_servo_step.sv -----
// Top level of the two-joint PD servo step: config registers, pipeline control, joints.
`default_nettype none

// Advances a two-joint arm by one time step per request. For each joint the block
// forms a PD acceleration kp*(target_angle - angle) + kd*(target_rate - rate),
// integrates velocity by the step h and clamps it to +/- velocity_limit, moves the
// angle by the trapezoid rule and the target angle by h*target_rate. States are
// signed Q16.16 (gains, h unsigned), rounded half away from zero, saturated to 32 bits.
// Throughput is one request per clock while results are taken; a request moves
// through the joint stages (errors, products, rounding, acceleration, h*acc, velocity
// clamp, velocity sum, h*sum, angle). Each stage holds its own valid bit and loads
// when it is empty or when the stage after it moves, so bubbles close up and a
// stalled result never blocks an earlier stage that still has room. The ready
// toward the request side is a combinational chain from the result ready. The
// config write port (cfg_we, cfg_idx, cfg_wdata) ignores unknown indexes; the user
// must write registers only while no request is in flight; the block does not check.

module two_joint_pd_servo_step
	import tjs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [DATA_W-1:0]    cfg_wdata,
	tjs_item_if.sink                  item,
	tjs_result_if.source              result
);

	// Configuration registers
	logic [DATA_W-1:0] kp0_q, kp1_q, kd0_q, kd1_q;
	logic [LIM_W-1:0]  vlim_q;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp0_q  <= DATA_W'(65536);
			kp1_q  <= DATA_W'(65536);
			kd0_q  <= '0;
			kd1_q  <= '0;
			vlim_q <= LIM_W'(65536);
			step_q <= STEP_W'(655);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KP0:  kp0_q  <= cfg_wdata;
				REG_KP1:  kp1_q  <= cfg_wdata;
				REG_KD0:  kd0_q  <= cfg_wdata;
				REG_KD1:  kd1_q  <= cfg_wdata;
				REG_VLIM: vlim_q <= cfg_wdata[LIM_W-1:0];
				REG_STEP: step_q <= cfg_wdata[STEP_W-1:0];
				default:  ;
			endcase
		end
	end

	// Pipeline control: per-stage valid bits and load strobes
	logic [NUM_STAGES-1:0] vld_q;
	pipe_ctl_t             ctl;

	always_comb begin
		ctl.load[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || result.ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			ctl.load[k] = !vld_q[k] || ctl.load[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ctl.load[0])
				vld_q[0] <= item.valid;
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (ctl.load[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign item.ready   = ctl.load[0];
	assign result.valid = vld_q[NUM_STAGES-1];

	joint_cfg_t cfg0, cfg1;

	assign cfg0 = '{kp: kp0_q, kd: kd0_q, lim: vlim_q, h: step_q};
	assign cfg1 = '{kp: kp1_q, kd: kd1_q, lim: vlim_q, h: step_q};

	logic signed [DATA_W-1:0] nang0, nrate0, ntgt0;
	logic signed [DATA_W-1:0] nang1, nrate1, ntgt1;

	tjs_joint u_joint0 (
		.clk       (clk),
		.ctl       (ctl),
		.cfg       (cfg0),
		.ang       ($signed(item.angle_0)),
		.rate      ($signed(item.rate_0)),
		.tgt       ($signed(item.target_angle_0)),
		.trate     ($signed(item.target_rate_0)),
		.next_ang  (nang0),
		.next_rate (nrate0),
		.next_tgt  (ntgt0)
	);

	tjs_joint u_joint1 (
		.clk       (clk),
		.ctl       (ctl),
		.cfg       (cfg1),
		.ang       ($signed(item.angle_1)),
		.rate      ($signed(item.rate_1)),
		.tgt       ($signed(item.target_angle_1)),
		.trate     ($signed(item.target_rate_1)),
		.next_ang  (nang1),
		.next_rate (nrate1),
		.next_tgt  (ntgt1)
	);

	assign result.next_angle_0  = nang0;
	assign result.next_angle_1  = nang1;
	assign result.next_rate_0   = nrate0;
	assign result.next_rate_1   = nrate1;
	assign result.next_target_0 = ntgt0;
	assign result.next_target_1 = ntgt1;

`ifndef SYNTHESIS
	// An accepted request lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> vld_q[0])
		else $error("accepted request missing from first stage");

	// A full pipeline behind a stalled result must refuse new requests
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !result.ready) |-> !item.ready)
		else $error("request taken while pipeline full and stalled");

	// A draining result side never holds off the request side
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> item.ready)
		else $error("request side stalled while result side drains");
`endif

endmodule

`default_nettype wire

// ----- sim/servo_step_check_pkg.sv -----
// Expected-step bookkeeping and bit-exact prediction for the two-joint servo step.
package servo_step_check_pkg;
	import tjs_pkg::*;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [DATA_W-1:0] angle_0, angle_1, rate_0, rate_1;
		logic [DATA_W-1:0] target_angle_0, target_angle_1, target_rate_0, target_rate_1;
	} step_request_t;

	typedef struct packed {
		logic [DATA_W-1:0] next_angle_0, next_angle_1, next_rate_0, next_rate_1;
		logic [DATA_W-1:0] next_target_0, next_target_1;
	} step_result_t;

	function automatic longint clamp_s32(longint v);
		if (v > S32_MAX) return S32_MAX;
		if (v < S32_MIN) return S32_MIN;
		return v;
	endfunction

	// a*b / 2^s, rounded to nearest, ties away from zero
	function automatic longint round_mul(longint a, logic [DATA_W-1:0] b, int s);
		logic [63:0]  mag;
		logic [127:0] prod;
		mag = (a < 0) ? -a : a;
		prod = mag * b;
		prod = (prod + (128'd1 << (s - 1))) >> s;
		return (a < 0) ? -$signed(prod[63:0]) : $signed(prod[63:0]);
	endfunction

	class servo_step_checker;
		logic [DATA_W-1:0] kp [2];
		logic [DATA_W-1:0] kd [2];
		logic [LIM_W-1:0]  vlim;
		logic [STEP_W-1:0] h;
		step_result_t      pending_steps [$];
		int                failures;
		int                shown;

		function new();
			kp[0] = 32'h0001_0000;
			kp[1] = 32'h0001_0000;
			kd[0] = '0;
			kd[1] = '0;
			vlim = 31'h0001_0000;
			h = 16'd655;
			failures = 0;
			shown = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_KP0: kp[0] = val;
				REG_KP1: kp[1] = val;
				REG_KD0: kd[0] = val;
				REG_KD1: kd[1] = val;
				REG_VLIM: vlim = val[LIM_W-1:0];
				REG_STEP: h = val[STEP_W-1:0];
				default: ;
			endcase
		endfunction

		function void advance_joint(input logic [DATA_W-1:0] ang_w, rate_w, tgt_w, trate_w,
				input logic [DATA_W-1:0] kp_g, kd_g,
				output logic [DATA_W-1:0] ang_o, rate_o, tgt_o);
			longint ang, rate, tgt, trate, accel, vel, lim, sum;
			ang = $signed(ang_w);
			rate = $signed(rate_w);
			tgt = $signed(tgt_w);
			trate = $signed(trate_w);
			lim = vlim;
			accel = clamp_s32(round_mul(tgt - ang, kp_g, 16) + round_mul(trate - rate, kd_g, 16));
			vel = rate + round_mul(accel, h, 16);
			if (vel < -lim) vel = -lim;
			if (vel > lim) vel = lim;
			rate_o = vel[31:0];
			// trapezoid: half of h*(v_new + v_old), hence the extra shift
			sum = clamp_s32(ang + round_mul(vel + rate, h, 17));
			ang_o = sum[31:0];
			sum = clamp_s32(tgt + round_mul(trate, h, 16));
			tgt_o = sum[31:0];
		endfunction

		function void note_request(step_request_t req);
			step_result_t res;
			advance_joint(req.angle_0, req.rate_0, req.target_angle_0, req.target_rate_0,
				kp[0], kd[0], res.next_angle_0, res.next_rate_0, res.next_target_0);
			advance_joint(req.angle_1, req.rate_1, req.target_angle_1, req.target_rate_1,
				kp[1], kd[1], res.next_angle_1, res.next_rate_1, res.next_target_1);
			pending_steps.push_back(res);
		endfunction

		function void check_field(string name, logic [DATA_W-1:0] want, got);
			if (got !== want) begin
				failures++;
				if (shown < 10) begin
					shown++;
					$display("result mismatch on %s: expected %h, got %h", name, want, got);
				end
			end
		endfunction

		function void check_result(step_result_t got);
			step_result_t want;
			if (pending_steps.size() == 0) begin
				failures++;
				if (shown < 10) begin
					shown++;
					$display("result with no request outstanding: %h", got);
				end
				return;
			end
			want = pending_steps.pop_front();
			check_field("next_angle_0", want.next_angle_0, got.next_angle_0);
			check_field("next_angle_1", want.next_angle_1, got.next_angle_1);
			check_field("next_rate_0", want.next_rate_0, got.next_rate_0);
			check_field("next_rate_1", want.next_rate_1, got.next_rate_1);
			check_field("next_target_0", want.next_target_0, got.next_target_0);
			check_field("next_target_1", want.next_target_1, got.next_target_1);
		endfunction

		function int outstanding();
			return pending_steps.size();
		endfunction
	endclass

endpackage

// ----- sim/tb.sv -----
// Self-checking bench for two_joint_pd_servo_step: directed corners, then random traffic.
module tb;
	import tjs_pkg::*;
	import servo_step_check_pkg::*;

	// cycles without any handshake before we call the run hung
	localparam int STALL_LIMIT = 4000;
	localparam int ITEMS_PER_SETTING = 96;
	// index past the register map; writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = '1;
	localparam logic [DATA_W-1:0] S_MAX = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] S_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] ALL_ONES = '1;
	localparam logic [DATA_W-1:0] STEP_MAX = 32'h0000_ffff;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [DATA_W-1:0]    cfg_wdata = '0;

	int send_idle_pct = 0;	// chance per cycle that the request side holds off
	int stall_pct = 0;	// chance per cycle that the result side stalls
	int idle_run = 0;

	servo_step_checker board;

	tjs_item_if   req_ch ();
	tjs_result_if res_ch ();

	two_joint_pd_servo_step uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (req_ch),
		.result    (res_ch)
	);

	always #5 clk = ~clk;

	// result side: random back-pressure at the current phase's rate
	always @(posedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Monitor: reads pre-edge values, so it sees exactly what the block sampled.
	// Accepted requests feed the predictor, accepted results are checked in order.
	always @(posedge clk) begin : watch
		step_request_t req;
		step_result_t  res;
		if (arst_n) begin
			req.angle_0 = req_ch.angle_0;
			req.angle_1 = req_ch.angle_1;
			req.rate_0 = req_ch.rate_0;
			req.rate_1 = req_ch.rate_1;
			req.target_angle_0 = req_ch.target_angle_0;
			req.target_angle_1 = req_ch.target_angle_1;
			req.target_rate_0 = req_ch.target_rate_0;
			req.target_rate_1 = req_ch.target_rate_1;
			res.next_angle_0 = res_ch.next_angle_0;
			res.next_angle_1 = res_ch.next_angle_1;
			res.next_rate_0 = res_ch.next_rate_0;
			res.next_rate_1 = res_ch.next_rate_1;
			res.next_target_0 = res_ch.next_target_0;
			res.next_target_1 = res_ch.next_target_1;
			if (req_ch.valid && req_ch.ready)
				board.note_request(req);
			if (res_ch.valid && res_ch.ready)
				board.check_result(res);
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_run = 0;
			else
				idle_run++;
			if (idle_run >= STALL_LIMIT) begin
				$display("two_joint_pd_servo_step test failed");
				$finish;
			end
		end
	end

	// Present one request and hold it until the block takes it. Valid stays
	// high into the next call unless that call starts with a hold-off.
	task automatic push_request(step_request_t req);
		int gap = 0;
		while ($urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.angle_0 <= req.angle_0;
		req_ch.angle_1 <= req.angle_1;
		req_ch.rate_0 <= req.rate_0;
		req_ch.rate_1 <= req.rate_1;
		req_ch.target_angle_0 <= req.target_angle_0;
		req_ch.target_angle_1 <= req.target_angle_1;
		req_ch.target_rate_0 <= req.target_rate_0;
		req_ch.target_rate_1 <= req.target_rate_1;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// Stop sending and wait until every predicted step has come back.
	// Polled on the falling edge so the monitor's update at the rising edge
	// is always complete.
	task automatic quiesce();
		req_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (board.outstanding() != 0);
		@(posedge clk);
	endtask

	// One write per cycle; cfg_we is left high for back-to-back writes.
	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		board.set_register(idx, val);
		@(posedge clk);
	endtask

	// Full register set; the unmapped write goes first and must change nothing.
	task automatic apply_settings(logic [DATA_W-1:0] kp0, kp1, kd0, kd1, lim, step);
		write_register(REG_UNMAPPED, $urandom());
		write_register(REG_KP0, kp0);
		write_register(REG_KP1, kp1);
		write_register(REG_KD0, kd0);
		write_register(REG_KD1, kd1);
		write_register(REG_VLIM, lim);
		write_register(REG_STEP, step);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly plausible servo settings, with zero, full scale and raw words
	// (junk above the register width included) mixed in.
	function automatic logic [DATA_W-1:0] rand_setting(logic [DATA_W-1:0] top,
			int unsigned typical);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return top;
			2, 3: return $urandom();
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	task automatic apply_random_settings();
		apply_settings(rand_setting(ALL_ONES, 64 << 16), rand_setting(ALL_ONES, 64 << 16),
			rand_setting(ALL_ONES, 16 << 16), rand_setting(ALL_ONES, 16 << 16),
			rand_setting(S_MAX, 64 << 16), rand_setting(STEP_MAX, 6554));
	endtask

	function automatic step_request_t make_request(logic [DATA_W-1:0] a0, a1, r0, r1,
			t0, t1, tr0, tr1);
		step_request_t req;
		req.angle_0 = a0;
		req.angle_1 = a1;
		req.rate_0 = r0;
		req.rate_1 = r1;
		req.target_angle_0 = t0;
		req.target_angle_1 = t1;
		req.target_rate_0 = tr0;
		req.target_rate_1 = tr1;
		return req;
	endfunction

	// kind 0-5: small values around zero (realistic servo states, varied scale)
	// kind 6-7: raw 32-bit words; kind 8-9: corner words mixed with raw ones
	function automatic logic [DATA_W-1:0] pick_word(int unsigned kind, int unsigned span);
		if (kind < 6)
			return 32'($urandom_range(0, 2 * span)) - 32'(span);
		if (kind < 8 || $urandom_range(0, 1) == 0)
			return $urandom();
		case ($urandom_range(0, 4))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3: return ALL_ONES;
			default: return 32'd1;
		endcase
	endfunction

	function automatic step_request_t rand_request();
		int unsigned kind;
		int unsigned span;
		kind = $urandom_range(0, 9);
		span = 1 << $urandom_range(4, 29);
		return make_request(pick_word(kind, span), pick_word(kind, span),
			pick_word(kind, span), pick_word(kind, span), pick_word(kind, span),
			pick_word(kind, span), pick_word(kind, span), pick_word(kind, span));
	endfunction

	// Corner requests: zeros, full-scale positive and negative, largest
	// errors of opposite sign per joint, all ones, and a small mixed state.
	task automatic run_directed();
		push_request(make_request('0, '0, '0, '0, '0, '0, '0, '0));
		push_request(make_request(S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
		push_request(make_request(S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
		push_request(make_request(S_MIN, S_MAX, S_MIN, S_MAX, S_MAX, S_MIN, S_MAX, S_MIN));
		push_request(make_request(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
			ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
		push_request(make_request(32'h0003_0000, 32'hfffe_8000, 32'h0000_8000, 32'hffff_0001,
			32'hfffe_0000, 32'h0002_7fff, 32'hffff_0000, 32'h0001_8000));
	endtask

	initial begin : stimulus
		// known values on every request input before the first edge
		req_ch.valid = 1'b0;
		req_ch.angle_0 = '0;
		req_ch.angle_1 = '0;
		req_ch.rate_0 = '0;
		req_ch.rate_1 = '0;
		req_ch.target_angle_0 = '0;
		req_ch.target_angle_1 = '0;
		req_ch.target_rate_0 = '0;
		req_ch.target_rate_1 = '0;
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners at reset settings, then at full-scale gains/limit/step
		run_directed();
		quiesce();
		apply_settings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, S_MAX, STEP_MAX);
		run_directed();
		// zero velocity limit: every new rate must come out zero
		quiesce();
		apply_settings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, '0, STEP_MAX);
		run_directed();
		// zero step: pass-through, rate still clamped (MIN rate hits -limit)
		quiesce();
		apply_settings(32'h0000_8000, 32'h0001_8000, 32'h0000_8000, 32'h0002_0000, S_MAX, '0);
		run_directed();

		// random traffic: four idling phases, three register settings each
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 76; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 76; end
				default: begin send_idle_pct = 24; stall_pct = 24; end
			endcase
			for (int blk = 0; blk < 3; blk++) begin
				quiesce();
				apply_random_settings();
				for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
					// let the pipeline run dry mid-stream now and then
					if (n == ITEMS_PER_SETTING / 2 || $urandom_range(0, 199) == 0)
						quiesce();
					push_request(rand_request());
				end
			end
		end

		quiesce();
		// extra cycles to catch stray results past the last expected one
		repeat (2 * NUM_STAGES) @(posedge clk);
		if (board.failures == 0 && board.outstanding() == 0)
			$display("two_joint_pd_servo_step test passed");
		else
			$display("two_joint_pd_servo_step test failed");
		$finish;
	end

endmodule
